### rtl/core/prime_sieve_goldbach_split_core_assert.svh
// Assertion macros shared by the prime sieve Goldbach split core.
`ifndef PRIME_SIEVE_GOLDBACH_SPLIT_CORE_ASSERT_SVH
`define PRIME_SIEVE_GOLDBACH_SPLIT_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define PSG_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst is high.
`define PSG_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### rtl/core/psg_pkg.sv
// Shared types, constants and control program of the prime sieve Goldbach split core.
package psg_pkg;

  localparam int MAX_VALUE_DEF = 65535;
  localparam int VALUE_W       = 16;
  localparam int CAND_W        = VALUE_W + 1;
  localparam int STEP_W        = 5;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD_N,
    OP_ADDR_CLR,
    OP_FILL,
    OP_I_INIT,
    OP_CALC_SQ,
    OP_READ_I,
    OP_J_INIT,
    OP_CLEAR_J,
    OP_I_INC,
    OP_SET_READY,
    OP_CAND_INIT,
    OP_READ_PAIR,
    OP_CAND_INC,
    OP_EMIT_FOUND,
    OP_EMIT_NONE
  } op_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_TABLE_READY,
    C_ADDR_NOT_LAST,
    C_SQ_GT_MAX,
    C_NOT_PRIME,
    C_J_NEXT_LE_MAX,
    C_N_ODD,
    C_CAND_OVER,
    C_PAIR_FOUND,
    C_OUT_FREE
  } cond_t;

  typedef struct packed {
    op_t               op;
    cond_t             cond;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic table_ready;
    logic addr_last;
    logic sq_gt_max;
    logic not_prime;
    logic j_next_le_max;
    logic n_odd;
    logic cand_over;
    logic pair_found;
    logic out_free;
  } flags_t;

  localparam logic [STEP_W-1:0] S_IDLE       = 5'd0;
  localparam logic [STEP_W-1:0] S_CHECK_RDY  = 5'd1;
  localparam logic [STEP_W-1:0] S_FILL_INIT  = 5'd2;
  localparam logic [STEP_W-1:0] S_FILL       = 5'd3;
  localparam logic [STEP_W-1:0] S_I_INIT     = 5'd4;
  localparam logic [STEP_W-1:0] S_SQ         = 5'd5;
  localparam logic [STEP_W-1:0] S_SQ_TEST    = 5'd6;
  localparam logic [STEP_W-1:0] S_READ_I     = 5'd7;
  localparam logic [STEP_W-1:0] S_J_INIT     = 5'd8;
  localparam logic [STEP_W-1:0] S_CLEAR      = 5'd9;
  localparam logic [STEP_W-1:0] S_I_INC      = 5'd10;
  localparam logic [STEP_W-1:0] S_SET_READY  = 5'd11;
  localparam logic [STEP_W-1:0] S_SEARCH     = 5'd12;
  localparam logic [STEP_W-1:0] S_PAIR       = 5'd13;
  localparam logic [STEP_W-1:0] S_PAIR_TEST  = 5'd14;
  localparam logic [STEP_W-1:0] S_CAND_INC   = 5'd15;
  localparam logic [STEP_W-1:0] S_FOUND      = 5'd16;
  localparam logic [STEP_W-1:0] S_FOUND_WAIT = 5'd17;
  localparam logic [STEP_W-1:0] S_NONE       = 5'd18;
  localparam logic [STEP_W-1:0] S_NONE_WAIT  = 5'd19;

  // Control program: a taken condition jumps to target, otherwise fall through.
  function automatic ctrl_t seq_rom(input logic [STEP_W-1:0] step);
    ctrl_t w;
    w = '{op: OP_NONE, cond: C_ALWAYS, target: S_IDLE};
    unique case (step)
      S_IDLE:       w = '{op: OP_LOAD_N,     cond: C_NO_INPUT,      target: S_IDLE};
      S_CHECK_RDY:  w = '{op: OP_NONE,       cond: C_TABLE_READY,   target: S_SEARCH};
      S_FILL_INIT:  w = '{op: OP_ADDR_CLR,   cond: C_NEVER,         target: S_IDLE};
      S_FILL:       w = '{op: OP_FILL,       cond: C_ADDR_NOT_LAST, target: S_FILL};
      S_I_INIT:     w = '{op: OP_I_INIT,     cond: C_NEVER,         target: S_IDLE};
      S_SQ:         w = '{op: OP_CALC_SQ,    cond: C_NEVER,         target: S_IDLE};
      S_SQ_TEST:    w = '{op: OP_NONE,       cond: C_SQ_GT_MAX,     target: S_SET_READY};
      S_READ_I:     w = '{op: OP_READ_I,     cond: C_NEVER,         target: S_IDLE};
      S_J_INIT:     w = '{op: OP_J_INIT,     cond: C_NOT_PRIME,     target: S_I_INC};
      S_CLEAR:      w = '{op: OP_CLEAR_J,    cond: C_J_NEXT_LE_MAX, target: S_CLEAR};
      S_I_INC:      w = '{op: OP_I_INC,      cond: C_ALWAYS,        target: S_SQ};
      S_SET_READY:  w = '{op: OP_SET_READY,  cond: C_NEVER,         target: S_IDLE};
      S_SEARCH:     w = '{op: OP_CAND_INIT,  cond: C_N_ODD,         target: S_NONE};
      S_PAIR:       w = '{op: OP_READ_PAIR,  cond: C_CAND_OVER,     target: S_NONE};
      S_PAIR_TEST:  w = '{op: OP_NONE,       cond: C_PAIR_FOUND,    target: S_FOUND};
      S_CAND_INC:   w = '{op: OP_CAND_INC,   cond: C_ALWAYS,        target: S_PAIR};
      S_FOUND:      w = '{op: OP_EMIT_FOUND, cond: C_OUT_FREE,      target: S_IDLE};
      S_FOUND_WAIT: w = '{op: OP_NONE,       cond: C_ALWAYS,        target: S_FOUND};
      S_NONE:       w = '{op: OP_EMIT_NONE,  cond: C_OUT_FREE,      target: S_IDLE};
      S_NONE_WAIT:  w = '{op: OP_NONE,       cond: C_ALWAYS,        target: S_NONE};
      default:      w = '{op: OP_NONE,       cond: C_ALWAYS,        target: S_IDLE};
    endcase
    return w;
  endfunction

endpackage

### rtl/core/psg_ram.sv
// Generic RAM: one write port, two registered read ports.
module psg_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

### rtl/core/psg_seq.sv
// Step counter and control store of the prime sieve Goldbach split core.
module psg_seq (
  input  logic            clk,
  input  logic            rst,
  input  psg_pkg::flags_t flags,
  output psg_pkg::ctrl_t  ctrl
);

  logic [psg_pkg::STEP_W-1:0] pc;
  logic [psg_pkg::STEP_W-1:0] pc_next;
  logic                       take;

  assign ctrl = psg_pkg::seq_rom(pc);

  always_comb begin
    take = 1'b0;
    unique case (ctrl.cond)
      psg_pkg::C_NEVER:         take = 1'b0;
      psg_pkg::C_ALWAYS:        take = 1'b1;
      psg_pkg::C_NO_INPUT:      take = !flags.in_valid;
      psg_pkg::C_TABLE_READY:   take = flags.table_ready;
      psg_pkg::C_ADDR_NOT_LAST: take = !flags.addr_last;
      psg_pkg::C_SQ_GT_MAX:     take = flags.sq_gt_max;
      psg_pkg::C_NOT_PRIME:     take = flags.not_prime;
      psg_pkg::C_J_NEXT_LE_MAX: take = flags.j_next_le_max;
      psg_pkg::C_N_ODD:         take = flags.n_odd;
      psg_pkg::C_CAND_OVER:     take = flags.cand_over;
      psg_pkg::C_PAIR_FOUND:    take = flags.pair_found;
      psg_pkg::C_OUT_FREE:      take = flags.out_free;
      default:                  take = 1'b0;
    endcase
    pc_next = take ? ctrl.target : pc + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= psg_pkg::S_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

### rtl/core/psg_dp.sv
// Datapath of the prime sieve Goldbach split core: counters, table and result register.
`include "prime_sieve_goldbach_split_core_assert.svh"

module psg_dp #(
  parameter int MAX_VALUE = psg_pkg::MAX_VALUE_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  psg_pkg::ctrl_t              ctrl,
  output psg_pkg::flags_t             flags,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [psg_pkg::VALUE_W-1:0] value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        found,
  output logic [psg_pkg::VALUE_W-1:0] small_prime,
  output logic [psg_pkg::VALUE_W-1:0] large_prime
);

  localparam int DEPTH = MAX_VALUE + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = AW + 1;
  localparam int SW    = 2 * AW;
  localparam int CMP_W = (CW > psg_pkg::CAND_W) ? CW : psg_pkg::CAND_W;

  localparam logic [CW-1:0]    MAX_CW  = CW'(MAX_VALUE);
  localparam logic [SW-1:0]    MAX_SW  = SW'(MAX_VALUE);
  localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_VALUE);

  logic [psg_pkg::VALUE_W-1:0] n;
  logic [CW-1:0]               addr;
  logic [AW-1:0]               i;
  logic [SW-1:0]               sq;
  logic [CW-1:0]               j;
  logic [CW-1:0]               j_next;
  logic [psg_pkg::CAND_W-1:0]  cand;
  logic [psg_pkg::VALUE_W-1:0] diff;
  logic [CMP_W-1:0]            cand_x;
  logic [CMP_W-1:0]            diff_x;
  logic                        a_in_q;
  logic                        b_in_q;
  logic                        table_ready;

  logic          we;
  logic [AW-1:0] waddr;
  logic          wdata;
  logic [AW-1:0] raddr_a;
  logic [AW-1:0] raddr_b;
  logic          rd_a;
  logic          rd_b;
  logic          out_free;
  logic          emit;

  assign j_next = j + CW'(i);
  assign diff   = n - cand[psg_pkg::VALUE_W-1:0];
  assign cand_x = CMP_W'(cand);
  assign diff_x = CMP_W'(diff);

  assign in_ready = (ctrl.op == psg_pkg::OP_LOAD_N) && !rst;
  assign out_free = !out_valid || out_ready;
  assign emit     = out_free &&
                    (ctrl.op == psg_pkg::OP_EMIT_FOUND || ctrl.op == psg_pkg::OP_EMIT_NONE);

  assign we      = (ctrl.op == psg_pkg::OP_FILL) || (ctrl.op == psg_pkg::OP_CLEAR_J);
  assign waddr   = (ctrl.op == psg_pkg::OP_FILL) ? addr[AW-1:0] : j[AW-1:0];
  // 0 and 1 go in as not prime during the fill
  assign wdata   = (ctrl.op == psg_pkg::OP_FILL) && (addr >= CW'(2));
  assign raddr_a = (ctrl.op == psg_pkg::OP_READ_I) ? i : cand_x[AW-1:0];
  assign raddr_b = diff_x[AW-1:0];

  psg_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_table (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  always_comb begin
    flags.in_valid      = in_valid;
    flags.table_ready   = table_ready;
    flags.addr_last     = (addr == MAX_CW);
    flags.sq_gt_max     = (sq > MAX_SW);
    flags.not_prime     = !rd_a;
    flags.j_next_le_max = (j_next <= MAX_CW);
    flags.n_odd         = n[0];
    flags.cand_over     = (cand >= {1'b0, n});
    // entries past the table count as not prime
    flags.pair_found    = rd_a && a_in_q && rd_b && b_in_q;
    flags.out_free      = out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      table_ready <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (ctrl.op == psg_pkg::OP_SET_READY) begin
        table_ready <= 1'b1;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    a_in_q <= (cand_x <= MAX_CMP);
    b_in_q <= (diff_x <= MAX_CMP);
    unique case (ctrl.op)
      psg_pkg::OP_LOAD_N: begin
        if (in_valid) begin
          n <= value;
        end
      end
      psg_pkg::OP_ADDR_CLR:  addr <= '0;
      psg_pkg::OP_FILL:      addr <= addr + 1'b1;
      psg_pkg::OP_I_INIT:    i    <= AW'(2);
      psg_pkg::OP_CALC_SQ:   sq   <= SW'(i) * SW'(i);
      psg_pkg::OP_J_INIT:    j    <= sq[CW-1:0];
      psg_pkg::OP_CLEAR_J:   j    <= j_next;
      psg_pkg::OP_I_INC:     i    <= i + 1'b1;
      psg_pkg::OP_CAND_INIT: cand <= psg_pkg::CAND_W'(3);
      psg_pkg::OP_CAND_INC:  cand <= cand + psg_pkg::CAND_W'(2);
      default: begin
      end
    endcase
    if (emit) begin
      if (ctrl.op == psg_pkg::OP_EMIT_FOUND) begin
        found       <= 1'b1;
        small_prime <= cand[psg_pkg::VALUE_W-1:0];
        large_prime <= diff;
      end else begin
        found       <= 1'b0;
        small_prime <= '0;
        large_prime <= '0;
      end
    end
  end

  `PSG_ASSERT_IMP(a_no_write_after_sieve, table_ready, !we)
  `PSG_ASSERT_NXT(a_pair_sums_to_value, emit && ctrl.op == psg_pkg::OP_EMIT_FOUND,
    ({1'b0, small_prime} + {1'b0, large_prime}) == {1'b0, $past(n)})
  `PSG_ASSERT_IMP(a_pair_is_odd, out_valid && found, small_prime[0] && large_prime[0])
  `PSG_ASSERT_IMP(a_miss_is_zero, out_valid && !found, small_prime == '0 && large_prime == '0)

endmodule

### rtl/core/prime_sieve_goldbach_split_core.sv
// Top level of the prime sieve Goldbach split core.
//
// Input channel s_axis carries one query value per item; output channel m_axis
// returns one result per query: the first pair of odd primes that sums to the
// value (smallest first), or found low with both primes zero.
// The first query after reset builds the primality table: a fill pass over
// addresses 0 to MAX_VALUE, then a sieve over the outer values up to
// sqrt(MAX_VALUE) that crosses out the multiples of each prime from its square
// upward. Later queries skip this.
// A query then tests the odd candidates from 3 upward until one completes the
// pair or the candidate reaches the value; each candidate needs one table read
// on both RAM ports and a test of the registered data. An odd value goes
// straight to the miss result without a search.
// The result waits in an output register; the next item is accepted while it
// is still held. If the receiver stalls, the core finishes the following query
// and holds there until the output register frees.
// Reset clears the table-ready flag and the output valid and holds s_axis_tready
// low; table contents are rebuilt on the next query.
module prime_sieve_goldbach_split_core #(
  parameter int MAX_VALUE = psg_pkg::MAX_VALUE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] value
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [15:0] small_prime, [31:16] large_prime
  output logic        m_axis_tuser    // [0] found
);

  psg_pkg::ctrl_t  ctrl;
  psg_pkg::flags_t flags;

  psg_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctrl  (ctrl)
  );

  psg_dp #(
    .MAX_VALUE (MAX_VALUE)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .flags       (flags),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .value       (s_axis_tdata),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .found       (m_axis_tuser),
    .small_prime (m_axis_tdata[15:0]),
    .large_prime (m_axis_tdata[31:16])
  );

endmodule
